[sv/lpie_pkg.sv]
// Shared types and constants for the length-prefixed integer encoder.
// No dependencies; compiled before every other file of the block.
package lpie_pkg;

	// Header marker bits.
	localparam logic [7:0] HDR_SIGNED   = 8'h40;
	localparam logic [7:0] HDR_UNSIGNED = 8'h80;
	localparam logic [7:0] SIGN_BIT     = 8'h80;

	// Bytes in one input value.
	localparam int unsigned VALUE_BYTES = 8;

	// Encoder sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_HEAD,
		ST_BODY
	} state_t;

	// Control from the sequencer to the digit unit.
	typedef struct packed {
		logic clear;
		logic step;
		logic negate;
	} dig_ctrl_t;

	// Status from the digit unit back to the sequencer.
	typedef struct packed {
		logic [3:0] count;
		logic       last;
	} dig_stat_t;

endpackage

[sv/lpie_in_if.sv]
// Input channel of the encoder: one value and its kind per transaction.
// Stands alone; uses no package.
interface lpie_in_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [63:0] value;

	modport source (output valid, output kind, output value, input ready);
	modport sink (input valid, input kind, input value, output ready);
endinterface

[sv/lpie_out_if.sv]
// Output channel of the encoder: one encoded byte per transaction.
// Stands alone; uses no package.
interface lpie_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_byte;

	modport source (output valid, output out_byte, output last_byte, input ready);
	modport sink (input valid, input out_byte, input last_byte, output ready);
endinterface

[sv/lpie_digit.sv]
// Byte-serial magnitude unit: negates a two's complement value one byte per
// cycle with a carry register and counts its significant bytes. Uses lpie_pkg.
module lpie_digit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lpie_pkg::dig_ctrl_t  ctrl,
	input  logic [7:0]           byte_in,
	output logic [7:0]           byte_out,
	output lpie_pkg::dig_stat_t  stat
);

	logic       carry_q;
	logic [2:0] idx_q;
	logic [3:0] count_q;

	// Negation is invert plus the carry that rippled up from lower bytes.
	always_comb begin
		if (ctrl.negate) begin
			byte_out = ~byte_in + {7'b0, carry_q};
		end else begin
			byte_out = byte_in;
		end
	end

	// Carry, byte index and the count of bytes up to the highest nonzero byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q <= 1'b1;
			idx_q   <= '0;
			count_q <= '0;
		end else if (ctrl.clear) begin
			carry_q <= 1'b1;
			idx_q   <= '0;
			count_q <= '0;
		end else if (ctrl.step) begin
			carry_q <= carry_q & (byte_in == 8'h00);
			idx_q   <= idx_q + 3'd1;
			if (byte_out != 8'h00) begin
				count_q <= {1'b0, idx_q} + 4'd1;
			end
		end
	end

	assign stat.count = count_q;
	assign stat.last  = (idx_q == 3'(lpie_pkg::VALUE_BYTES - 1));

endmodule

[sv/length_prefixed_int_encoder_top.sv]
// Top level of the length-prefixed integer encoder: sequencer, 64-bit byte
// shift register and output register. Uses lpie_pkg, lpie_in_if, lpie_out_if
// and lpie_digit.
//
// Channel    Role    Payload               Handshake
// value_ch   sink    kind, value[63:0]     valid/ready
// byte_ch    source  out_byte[7:0], last   valid/ready
//
// One value is accepted, then scanned through lpie_digit one byte of the magnitude
// per cycle for all eight bytes, and then emitted at one byte per cycle while
// byte_ch keeps up; a code is one byte or a header and up to eight body bytes.
// The next value is accepted once the last byte sits in the output register.
// A stalled byte_ch holds the output register and the sequencer waits.
// Reset clears the sequencer and the output valid flag.
module length_prefixed_int_encoder_top (
	input  logic            clk,
	input  logic            arst_n,
	lpie_in_if.sink         value_ch,
	lpie_out_if.source      byte_ch
);

	lpie_pkg::state_t    state_q, state_d;
	lpie_pkg::dig_ctrl_t dig_ctrl;
	lpie_pkg::dig_stat_t dig_stat;

	logic [63:0] value_q;
	logic        kind_q;
	logic        sign_q;
	logic [3:0]  remaining_q;
	logic [7:0]  mag_byte;
	logic        accept;
	logic        out_load;
	logic        short_code;
	logic [7:0]  head_byte;
	logic [7:0]  load_byte;
	logic        load_last;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_last_q;

	assign accept   = value_ch.valid && value_ch.ready;
	assign out_load = ((state_q == lpie_pkg::ST_HEAD) || (state_q == lpie_pkg::ST_BODY))
		&& (!out_valid_q || byte_ch.ready);

	// Magnitude digit unit.
	assign dig_ctrl.clear  = accept;
	assign dig_ctrl.step   = (state_q == lpie_pkg::ST_SCAN);
	assign dig_ctrl.negate = sign_q;

	lpie_digit u_digit (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (dig_ctrl),
		.byte_in  (value_q[7:0]),
		.byte_out (mag_byte),
		.stat     (dig_stat)
	);

	// Header or single-byte code, chosen from the count and the low byte.
	always_comb begin
		if (kind_q) begin
			short_code = (dig_stat.count <= 4'd1) && (value_q[7:6] == 2'b00);
			if (short_code) begin
				head_byte = (sign_q ? lpie_pkg::SIGN_BIT : 8'h00) | {2'b00, value_q[5:0]};
			end else begin
				head_byte = lpie_pkg::HDR_SIGNED | (sign_q ? lpie_pkg::SIGN_BIT : 8'h00)
					| {4'b0000, dig_stat.count};
			end
		end else begin
			short_code = (dig_stat.count <= 4'd1) && !value_q[7];
			if (short_code) begin
				head_byte = {1'b0, value_q[6:0]};
			end else begin
				head_byte = lpie_pkg::HDR_UNSIGNED | {4'b0000, dig_stat.count};
			end
		end
	end

	// Next state and the byte offered to the output register.
	always_comb begin
		state_d        = state_q;
		value_ch.ready = 1'b0;
		load_byte      = head_byte;
		load_last      = 1'b0;
		case (state_q)
			lpie_pkg::ST_IDLE: begin
				value_ch.ready = 1'b1;
				if (value_ch.valid) begin
					state_d = lpie_pkg::ST_SCAN;
				end
			end
			lpie_pkg::ST_SCAN: begin
				if (dig_stat.last) begin
					state_d = lpie_pkg::ST_HEAD;
				end
			end
			lpie_pkg::ST_HEAD: begin
				load_byte = head_byte;
				load_last = short_code;
				if (out_load) begin
					state_d = short_code ? lpie_pkg::ST_IDLE : lpie_pkg::ST_BODY;
				end
			end
			lpie_pkg::ST_BODY: begin
				load_byte = value_q[7:0];
				load_last = (remaining_q == 4'd1);
				if (out_load && load_last) begin
					state_d = lpie_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lpie_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpie_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Byte shift register: rotates through the digit unit during the scan,
	// then shifts out one byte per emitted body byte.
	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= value_ch.value;
			kind_q  <= value_ch.kind;
			sign_q  <= value_ch.kind & value_ch.value[63];
		end else if (state_q == lpie_pkg::ST_SCAN) begin
			value_q <= {mag_byte, value_q[63:8]};
		end else if (out_load && (state_q == lpie_pkg::ST_BODY)) begin
			value_q <= {8'h00, value_q[63:8]};
		end
	end

	// Body byte counter.
	always_ff @(posedge clk) begin
		if (out_load && (state_q == lpie_pkg::ST_HEAD)) begin
			remaining_q <= dig_stat.count;
		end else if (out_load && (state_q == lpie_pkg::ST_BODY)) begin
			remaining_q <= remaining_q - 4'd1;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (byte_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_byte_q <= load_byte;
			out_last_q <= load_last;
		end
	end

	assign byte_ch.valid     = out_valid_q;
	assign byte_ch.out_byte  = out_byte_q;
	assign byte_ch.last_byte = out_last_q;

	// An accepted value always starts a scan.
	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == lpie_pkg::ST_SCAN))
		else $error("accepted value did not start a scan");

	// The scan ends after the eighth byte.
	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == lpie_pkg::ST_SCAN) && dig_stat.last) |=> (state_q == lpie_pkg::ST_HEAD))
		else $error("scan did not end on the last byte");

	// The significant byte count fits the value.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lpie_pkg::ST_HEAD) |-> (dig_stat.count <= 4'd8))
		else $error("byte count above eight");

	// Body bytes are emitted only while some remain.
	a_body_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lpie_pkg::ST_BODY) |-> (remaining_q != 4'd0))
		else $error("body state with no bytes left");

	// Loading the final byte returns the sequencer to idle.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && load_last) |=> (state_q == lpie_pkg::ST_IDLE))
		else $error("final byte did not end the encoding");

endmodule
